/* rtl/core/gbn_pkg.sv */
package gbn_pkg;

  localparam int unsigned SEQ_W        = 16;
  localparam int unsigned LEN_W        = 7;
  localparam int unsigned WIN_W        = 4;
  localparam int unsigned TMO_W        = 16;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned ACT_W        = 2;
  localparam int unsigned SLOT_PORT_W  = 4;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CNT_W        = WIN_W;

  localparam int unsigned WINDOW_MAX   = 8;
  localparam int unsigned MAX_SEGMENT  = 79;
  localparam int unsigned BUFFER_SLOTS = 16;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4);
  localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(1000);

  typedef enum logic [OP_W-1:0] {
    OP_SEGMENT = 2'd0,
    OP_END     = 2'd1,
    OP_ACK     = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_SEND   = 2'd0,
    ACT_RETX   = 2'd1,
    ACT_EOT    = 2'd2,
    ACT_REFUSE = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE   = 1'd0,
    REG_TIMEOUT_TICKS = 1'd1
  } cfg_reg_e;

  typedef enum logic {
    CMD_SINGLE = 1'b0,
    CMD_BURST  = 1'b1
  } cmd_kind_e;

  // One command from the front to the back. For a burst, seq is the window
  // base and count the number of segments to resend.
  typedef struct packed {
    cmd_kind_e         kind;
    action_e           action;
    logic [SEQ_W-1:0]  seq;
    logic [LEN_W-1:0]  len;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [SEQ_W-1:0]  seq;
    logic [LEN_W-1:0]  len;
  } mem_wr_t;

  typedef struct packed {
    logic burst_done;
  } back_status_t;

endpackage

/* rtl/core/go_back_n_sender_window_unit.sv */
// Go-Back-N sender window.
// Input channel (in_valid_i/in_ready_o) carries one event word: a segment
// offer with its length, end of data, a cumulative ACK, or a timer tick.
// Output channel (out_valid_o/out_ready_i) carries result words: new sends,
// refusals, retransmits and end of transmission; last_o marks the final
// word caused by one event. The config channel writes window_size (index 0)
// and timeout_ticks (index 1); it is always ready.
// An accepted event's command is registered in the two-entry command queue,
// then its result word in the output register. Events that give at most one
// word are taken one per cycle while the queue has room.
// A timeout burst of n outstanding segments, at most eight, leaves the back
// end at one word per cycle while the output is free, after a registered
// slot-length read; events are held off from the timeout tick until the
// last burst word is loaded, since the slot-length memory port is then busy.
// When the receiver stalls, the output register holds its word, the queue
// fills, and in_ready_o drops.
// Reset clears window state, flags and the queue and loads window_size 4,
// timeout_ticks 1000; the slot-length memory is not cleared.
// BUFFER_SLOTS must be a power of two.
module go_back_n_sender_window_unit
  import gbn_pkg::*;
#(
  parameter int unsigned BUFFER_SLOTS = gbn_pkg::BUFFER_SLOTS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [OP_W-1:0]        op_i,
  input  logic [LEN_W-1:0]       segment_length_i,
  input  logic [SEQ_W-1:0]       ack_number_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ACT_W-1:0]       action_o,
  output logic [SEQ_W-1:0]       seq_number_o,
  output logic [SLOT_PORT_W-1:0] buffer_slot_o,
  output logic [LEN_W-1:0]       byte_count_o,
  output logic                   last_o
);

  cmd_t         push_cmd;
  cmd_t         head_cmd;
  logic         push;
  logic         pop;
  logic         fifo_full;
  logic         fifo_empty;
  mem_wr_t      mem_wr;
  back_status_t back_status;

  // Front: config registers, window bookkeeping, event classification.
  gbn_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .segment_length_i (segment_length_i),
    .ack_number_i     (ack_number_i),
    .fifo_full_i      (fifo_full),
    .push_o           (push),
    .cmd_o            (push_cmd),
    .mem_wr_o         (mem_wr),
    .back_status_i    (back_status)
  );

  // Decouple the two sides.
  gbn_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  // Back: slot-length memory, burst sequencer, output register.
  gbn_back #(
    .BUFFER_SLOTS (BUFFER_SLOTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_cmd),
    .empty_i       (fifo_empty),
    .pop_o         (pop),
    .mem_wr_i      (mem_wr),
    .status_o      (back_status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .action_o      (action_o),
    .seq_number_o  (seq_number_o),
    .buffer_slot_o (buffer_slot_o),
    .byte_count_o  (byte_count_o),
    .last_o        (last_o)
  );

endmodule

/* rtl/core/gbn_front.sv */
module gbn_front
  import gbn_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic [LEN_W-1:0]      segment_length_i,
  input  logic [SEQ_W-1:0]      ack_number_i,
  input  logic                  fifo_full_i,
  output logic                  push_o,
  output cmd_t                  cmd_o,
  output mem_wr_t               mem_wr_o,
  input  back_status_t          back_status_i
);

  logic [WIN_W-1:0] win_q;
  logic [TMO_W-1:0] tmo_q;
  logic [SEQ_W-1:0] base_q, base_d;
  logic [SEQ_W-1:0] next_q, next_d;
  logic [TMO_W-1:0] tcnt_q, tcnt_d;
  logic             run_q, run_d;
  logic             end_q, end_d;
  logic             fin_q, fin_d;
  logic             bpend_q, bpend_d;

  logic [WIN_W-1:0] win_eff;
  logic [TMO_W-1:0] limit;
  logic [SEQ_W-1:0] outs;
  logic [SEQ_W-1:0] ack_off;
  logic [SEQ_W-1:0] ack_next;
  logic [TMO_W-1:0] tcnt_inc;
  logic [LEN_W-1:0] len_sat;
  logic             accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !fifo_full_i && !bpend_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    if (win_q == '0) begin
      win_eff = WIN_W'(1);
    end else if (win_q > WIN_W'(WINDOW_MAX)) begin
      win_eff = WIN_W'(WINDOW_MAX);
    end else begin
      win_eff = win_q;
    end
  end

  assign limit    = (tmo_q == '0) ? TMO_W'(1) : tmo_q;
  assign outs     = next_q - base_q;
  assign ack_off  = ack_number_i - base_q;
  assign ack_next = ack_number_i + SEQ_W'(1);
  assign tcnt_inc = tcnt_q + TMO_W'(1);
  assign len_sat  = (segment_length_i > LEN_W'(MAX_SEGMENT)) ? LEN_W'(MAX_SEGMENT)
                                                             : segment_length_i;

  always_comb begin
    base_d   = base_q;
    next_d   = next_q;
    tcnt_d   = tcnt_q;
    run_d    = run_q;
    end_d    = end_q;
    fin_d    = fin_q;
    bpend_d  = bpend_q;
    push_o   = 1'b0;
    cmd_o    = '{kind: CMD_SINGLE, action: ACT_SEND, seq: next_q, len: len_sat,
                 count: '0};
    mem_wr_o = '{en: 1'b0, seq: next_q, len: len_sat};

    if (back_status_i.burst_done) begin
      bpend_d = 1'b0;
    end

    if (accept && !fin_q) begin
      unique case (op_e'(op_i))
        OP_SEGMENT: begin
          if (!end_q) begin
            push_o = 1'b1;
            if (outs >= SEQ_W'(win_eff)) begin
              cmd_o.action = ACT_REFUSE;
            end else begin
              mem_wr_o.en = 1'b1;
              if (outs == '0) begin
                run_d  = 1'b1;
                tcnt_d = '0;
              end
              next_d = next_q + SEQ_W'(1);
            end
          end
        end
        OP_END: begin
          end_d = 1'b1;
          if (outs == '0) begin
            push_o       = 1'b1;
            cmd_o.action = ACT_EOT;
            cmd_o.len    = '0;
            fin_d        = 1'b1;
            run_d        = 1'b0;
            tcnt_d       = '0;
          end
        end
        OP_ACK: begin
          if (ack_off < outs) begin
            base_d = ack_next;
            tcnt_d = '0;
            if (next_q == ack_next) begin
              run_d = 1'b0;
              if (end_q) begin
                push_o       = 1'b1;
                cmd_o.action = ACT_EOT;
                cmd_o.len    = '0;
                fin_d        = 1'b1;
              end
            end else begin
              run_d = 1'b1;
            end
          end
        end
        OP_TICK: begin
          if (run_q) begin
            if (tcnt_inc >= limit) begin
              tcnt_d = '0;
              if (outs != '0) begin
                push_o       = 1'b1;
                bpend_d      = 1'b1;
                cmd_o.kind   = CMD_BURST;
                cmd_o.action = ACT_RETX;
                cmd_o.seq    = base_q;
                cmd_o.count  = (outs > SEQ_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX)
                                                           : outs[CNT_W-1:0];
              end
            end else begin
              tcnt_d = tcnt_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_RESET;
      tmo_q <= TMO_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_WINDOW_SIZE:   win_q <= cfg_data_i[WIN_W-1:0];
        REG_TIMEOUT_TICKS: tmo_q <= cfg_data_i[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      next_q  <= '0;
      tcnt_q  <= '0;
      run_q   <= 1'b0;
      end_q   <= 1'b0;
      fin_q   <= 1'b0;
      bpend_q <= 1'b0;
    end else begin
      base_q  <= base_d;
      next_q  <= next_d;
      tcnt_q  <= tcnt_d;
      run_q   <= run_d;
      end_q   <= end_d;
      fin_q   <= fin_d;
      bpend_q <= bpend_d;
    end
  end

endmodule

/* rtl/core/gbn_cmd_fifo.sv */
module gbn_cmd_fifo
  import gbn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/core/gbn_back.sv */
module gbn_back
  import gbn_pkg::*;
#(
  parameter int unsigned BUFFER_SLOTS = gbn_pkg::BUFFER_SLOTS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   head_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  input  mem_wr_t                mem_wr_i,
  output back_status_t           status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ACT_W-1:0]       action_o,
  output logic [SEQ_W-1:0]       seq_number_o,
  output logic [SLOT_PORT_W-1:0] buffer_slot_o,
  output logic [LEN_W-1:0]       byte_count_o,
  output logic                   last_o
);

  localparam int unsigned SLOT_W = $clog2(BUFFER_SLOTS);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_BURST = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [SEQ_W-1:0] base_q, base_d;
  logic [CNT_W-1:0] num_q, num_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [LEN_W-1:0] slot_len_q [BUFFER_SLOTS];
  logic [LEN_W-1:0] rd_data_q;
  logic             rd_en;
  logic [SEQ_W-1:0] rd_seq;

  logic             out_valid_q, out_valid_d;
  action_e          action_q, action_d;
  logic [SEQ_W-1:0] seq_q, seq_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             last_q, last_d;
  logic             load;
  logic             out_free;
  logic             burst_last;
  logic [SEQ_W-1:0] burst_seq;

  assign out_free   = !out_valid_q || out_ready_i;
  assign burst_seq  = base_q + SEQ_W'(cnt_q);
  assign burst_last = (CNT_W'(cnt_q + CNT_W'(1)) == num_q);

  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    num_d      = num_q;
    cnt_d      = cnt_q;
    pop_o      = 1'b0;
    rd_en      = 1'b0;
    rd_seq     = head_i.seq;
    load       = 1'b0;
    action_d   = action_q;
    seq_d      = seq_q;
    len_d      = len_q;
    last_d     = last_q;
    status_o   = '{burst_done: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          if (head_i.kind == CMD_BURST) begin
            // Fetch the base slot while taking the command.
            pop_o   = 1'b1;
            rd_en   = 1'b1;
            base_d  = head_i.seq;
            num_d   = head_i.count;
            cnt_d   = '0;
            state_d = S_BURST;
          end else if (out_free) begin
            pop_o    = 1'b1;
            load     = 1'b1;
            action_d = head_i.action;
            seq_d    = head_i.seq;
            len_d    = head_i.len;
            last_d   = 1'b1;
          end
        end
      end
      S_BURST: begin
        if (out_free) begin
          load     = 1'b1;
          action_d = ACT_RETX;
          seq_d    = burst_seq;
          len_d    = rd_data_q;
          last_d   = burst_last;
          if (burst_last) begin
            status_o.burst_done = 1'b1;
            state_d             = S_IDLE;
          end else begin
            rd_en  = 1'b1;
            rd_seq = burst_seq + SEQ_W'(1);
            cnt_d  = cnt_q + CNT_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      slot_len_q[mem_wr_i.seq[SLOT_W-1:0]] <= mem_wr_i.len;
    end
    if (rd_en) begin
      rd_data_q <= slot_len_q[rd_seq[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    seq_q    <= seq_d;
    len_q    <= len_d;
    last_q   <= last_d;
    base_q   <= base_d;
    num_q    <= num_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = action_q;
  assign seq_number_o  = seq_q;
  assign buffer_slot_o = SLOT_PORT_W'(seq_q[SLOT_W-1:0]);
  assign byte_count_o  = len_q;
  assign last_o        = last_q;

endmodule

/* rtl/core/gbn_checker.sv */
module gbn_checker
  import gbn_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o,
  input logic [CFG_IDX_W-1:0]   cfg_index_i,
  input logic [CFG_DATA_W-1:0]  cfg_data_i,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [OP_W-1:0]        op_i,
  input logic [LEN_W-1:0]       segment_length_i,
  input logic [SEQ_W-1:0]       ack_number_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [ACT_W-1:0]       action_o,
  input logic [SEQ_W-1:0]       seq_number_o,
  input logic [SLOT_PORT_W-1:0] buffer_slot_o,
  input logic [LEN_W-1:0]       byte_count_o,
  input logic                   last_o
);

  // Hold a stalled output word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(action_o)
      && $stable(seq_number_o) && $stable(byte_count_o) && $stable(last_o))
    else $error("stalled output word changed");

  // Only retransmit bursts span several words.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o != ACT_RETX) |-> last_o)
    else $error("non-burst word without last");

  // End of transmission carries no bytes.
  a_eot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == ACT_EOT) |-> (byte_count_o == '0))
    else $error("end of transmission with nonzero byte count");

  // Lengths are saturated.
  a_len_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_count_o <= LEN_W'(MAX_SEGMENT)))
    else $error("byte count above maximum segment");

endmodule

bind go_back_n_sender_window_unit gbn_checker u_gbn_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import gbn_pkg::*;

  // Result words pass the command queue and the output register; a timeout
  // burst adds a slot read plus up to eight words. Wait this long once the queue of expected words is empty.
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    action_e                action;
    logic [SEQ_W-1:0]       seq;
    logic [SLOT_PORT_W-1:0] slot;
    logic [LEN_W-1:0]       bytes;
    logic                   last;
  } tx_word_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [OP_W-1:0]        op_i;
  logic [LEN_W-1:0]       segment_length_i;
  logic [SEQ_W-1:0]       ack_number_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [ACT_W-1:0]       action_o;
  logic [SEQ_W-1:0]       seq_number_o;
  logic [SLOT_PORT_W-1:0] buffer_slot_o;
  logic [LEN_W-1:0]       byte_count_o;
  logic                   last_o;

  // Sender window shadow: config, window pointers, timer, flags, lengths.
  logic [WIN_W-1:0] win_reg;
  logic [TMO_W-1:0] tmo_reg;
  logic [SEQ_W-1:0] win_base;
  logic [SEQ_W-1:0] next_seq;
  logic [TMO_W-1:0] tick_count;
  logic             timer_on;
  logic             end_seen;
  logic             eot_sent;
  logic [LEN_W-1:0] seg_len [BUFFER_SLOTS];

  tx_word_t expected_words[$];
  int       mismatch_count;
  int       sender_gap_pct;
  int       receiver_stall_pct;

  go_back_n_sender_window_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .segment_length_i (segment_length_i),
    .ack_number_i     (ack_number_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .action_o         (action_o),
    .seq_number_o     (seq_number_o),
    .buffer_slot_o    (buffer_slot_o),
    .byte_count_o     (byte_count_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Queue one expected word.
  function automatic void expect_word(action_e act, logic [SEQ_W-1:0] seq,
                                      logic [LEN_W-1:0] bytes, logic last);
    tx_word_t w;
    w.action = act;
    w.seq    = seq;
    w.slot   = seq[SLOT_PORT_W-1:0];
    w.bytes  = bytes;
    w.last   = last;
    expected_words.push_back(w);
  endfunction

  // Advance the window shadow by one accepted event and queue the words it
  // causes.
  function automatic void advance_window(op_e op, logic [LEN_W-1:0] len,
                                         logic [SEQ_W-1:0] ack);
    int unsigned      win;
    int unsigned      limit;
    int unsigned      burst;
    logic [SEQ_W-1:0] inflight;
    logic [SEQ_W-1:0] ack_off;
    logic [SEQ_W-1:0] s;
    logic [LEN_W-1:0] clen;
    win = win_reg;
    if (win < 1) win = 1;
    if (win > WINDOW_MAX) win = WINDOW_MAX;
    limit = (tmo_reg == '0) ? 1 : tmo_reg;
    inflight = next_seq - win_base;
    // Drop everything once end of transmission has gone out.
    if (eot_sent) return;
    case (op)
      OP_SEGMENT: begin
        if (end_seen) return;
        clen = (len > MAX_SEGMENT) ? LEN_W'(MAX_SEGMENT) : len;
        if (inflight >= win) begin
          expect_word(ACT_REFUSE, next_seq, clen, 1'b1);
        end else begin
          seg_len[next_seq[SLOT_PORT_W-1:0]] = clen;
          expect_word(ACT_SEND, next_seq, clen, 1'b1);
          if (inflight == '0) begin
            timer_on   = 1'b1;
            tick_count = '0;
          end
          next_seq = next_seq + 1'b1;
        end
      end
      OP_END: begin
        end_seen = 1'b1;
        if (inflight == '0) begin
          expect_word(ACT_EOT, next_seq, '0, 1'b1);
          eot_sent   = 1'b1;
          timer_on   = 1'b0;
          tick_count = '0;
        end
      end
      OP_ACK: begin
        ack_off = ack - win_base;
        if (ack_off >= inflight) return;
        win_base   = ack + 1'b1;
        tick_count = '0;
        if (next_seq == win_base) begin
          timer_on = 1'b0;
          if (end_seen) begin
            expect_word(ACT_EOT, next_seq, '0, 1'b1);
            eot_sent = 1'b1;
          end
        end else begin
          timer_on = 1'b1;
        end
      end
      default: begin
        if (!timer_on) return;
        tick_count = tick_count + 1'b1;
        if (tick_count < limit) return;
        tick_count = '0;
        burst = (inflight > WINDOW_MAX) ? WINDOW_MAX : inflight;
        for (int unsigned i = 0; i < burst; i++) begin
          s = win_base + SEQ_W'(i);
          expect_word(ACT_RETX, s, seg_len[s[SLOT_PORT_W-1:0]], i + 1 == burst);
        end
      end
    endcase
  endfunction

  // Present one event word, idling first at the sender's rate; hold it until
  // taken. Valid is left high so that back-to-back words need no extra edge.
  task automatic push_event(op_e op, logic [LEN_W-1:0] len, logic [SEQ_W-1:0] ack);
    @(negedge clk_i);
    if ($urandom_range(99) < sender_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < sender_gap_pct);
    end
    in_valid_i       <= 1'b1;
    op_i             <= op;
    segment_length_i <= len;
    ack_number_i     <= ack;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_window(op, len, ack);
  endtask

  // Drop valid, wait for every expected word, then let the pipeline drain
  // events that give no word.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register while the block is idle.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_WINDOW_SIZE) win_reg = data[WIN_W-1:0];
    else tmo_reg = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Reset config: idle tick, an ack with nothing outstanding, length extremes,
  // saturation, window full, stale and future acks, full drain.
  task automatic test_reset_values();
    push_event(OP_TICK, 7'd0, 16'd0);
    push_event(OP_ACK, 7'd0, 16'd0);
    push_event(OP_SEGMENT, 7'd0, 16'd0);
    push_event(OP_SEGMENT, 7'd79, 16'd0);
    push_event(OP_SEGMENT, 7'd127, 16'd0);
    push_event(OP_SEGMENT, 7'd80, 16'd0);
    push_event(OP_SEGMENT, 7'd42, 16'd0);
    push_event(OP_ACK, 7'd0, next_seq);
    push_event(OP_ACK, 7'd0, 16'hFFFF);
    push_event(OP_ACK, 7'd0, next_seq - 1'b1);
  endtask

  // Register extremes: window zero and timeout zero count as one; an
  // oversized window caps at eight with a full burst; a shrunk window
  // refuses until acks drain it; the largest timeout never fires here.
  task automatic test_register_extremes();
    write_reg(REG_WINDOW_SIZE, 16'd0);
    write_reg(REG_TIMEOUT_TICKS, 16'd0);
    push_event(OP_SEGMENT, 7'd5, 16'd0);
    push_event(OP_SEGMENT, 7'd6, 16'd0);
    push_event(OP_TICK, 7'd0, 16'd0);
    push_event(OP_ACK, 7'd0, win_base);

    write_reg(REG_WINDOW_SIZE, 16'd15);
    write_reg(REG_TIMEOUT_TICKS, 16'd1);
    repeat (WINDOW_MAX) push_event(OP_SEGMENT, LEN_W'($urandom_range(MAX_SEGMENT)), 16'd0);
    push_event(OP_SEGMENT, 7'd11, 16'd0);
    push_event(OP_TICK, 7'd0, 16'd0);

    write_reg(REG_WINDOW_SIZE, 16'd2);
    write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
    push_event(OP_SEGMENT, 7'd12, 16'd0);
    push_event(OP_ACK, 7'd0, win_base + 16'd5);
    push_event(OP_SEGMENT, 7'd13, 16'd0);
    push_event(OP_ACK, 7'd0, win_base);
    push_event(OP_SEGMENT, 7'd14, 16'd0);
    push_event(OP_TICK, 7'd0, 16'd0);
  endtask

  // Random traffic: mostly offers and in-window acks with ticks between,
  // plus acks anywhere in the sequence space. End of data is held back for
  // the last test since it shuts the block for good.
  task automatic test_random_traffic(int count, int gap_pct, int stall_pct,
                                     logic [CFG_DATA_W-1:0] win,
                                     logic [CFG_DATA_W-1:0] tmo);
    int unsigned      pick;
    logic [SEQ_W-1:0] inflight;
    logic [SEQ_W-1:0] ackv;
    logic [LEN_W-1:0] len;
    write_reg(REG_WINDOW_SIZE, win);
    write_reg(REG_TIMEOUT_TICKS, tmo);
    sender_gap_pct     = gap_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) begin
      inflight = next_seq - win_base;
      pick     = $urandom_range(99);
      if ($urandom_range(99) < 85) len = LEN_W'($urandom_range(MAX_SEGMENT));
      else len = LEN_W'($urandom_range(127, MAX_SEGMENT + 1));
      ackv = SEQ_W'($urandom_range(16'hFFFF));
      if (pick < 40) begin
        push_event(OP_SEGMENT, len, ackv);
      end else if (pick < 70) begin
        if (inflight != '0 && $urandom_range(3) != 0)
          ackv = win_base + SEQ_W'($urandom_range(inflight - 1));
        push_event(OP_ACK, len, ackv);
      end else begin
        push_event(OP_TICK, len, ackv);
      end
    end
  endtask

  // End of data with segments outstanding: no word yet, later offers and a
  // repeated end are ignored, timeouts still resend, the draining ack sends
  // end of transmission, and nothing after it has any effect.
  task automatic test_end_of_data();
    push_event(OP_SEGMENT, 7'd10, 16'd0);
    push_event(OP_END, 7'd0, 16'd0);
    push_event(OP_SEGMENT, 7'd33, 16'd0);
    push_event(OP_END, 7'd0, 16'd0);
    repeat ((tmo_reg == '0) ? 1 : int'(tmo_reg)) push_event(OP_TICK, 7'd0, 16'd0);
    push_event(OP_ACK, 7'd0, next_seq - 1'b1);
    push_event(OP_SEGMENT, 7'd20, 16'd0);
    push_event(OP_ACK, 7'd0, next_seq);
    push_event(OP_TICK, 7'd0, 16'd0);
    push_event(OP_END, 7'd0, 16'd0);
  endtask

  // Take a word when valid and ready meet at the rising edge and compare it
  // with the oldest expected word.
  always @(posedge clk_i) begin : check_words
    tx_word_t got;
    tx_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.action = action_e'(action_o);
      got.seq    = seq_number_o;
      got.slot   = buffer_slot_o;
      got.bytes  = byte_count_o;
      got.last   = last_o;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word act=%0d seq=%0d slot=%0d bytes=%0d last=%0d",
                 $time, got.action, got.seq, got.slot, got.bytes, got.last);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          $display("%0t: word mismatch exp act=%0d seq=%0d slot=%0d bytes=%0d last=%0d",
                   $time, want.action, want.seq, want.slot, want.bytes, want.last);
          $display("%0t:                got act=%0d seq=%0d slot=%0d bytes=%0d last=%0d",
                   $time, got.action, got.seq, got.slot, got.bytes, got.last);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver stalls at its current rate, one decision per cycle.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = REG_WINDOW_SIZE;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    op_i               = OP_TICK;
    segment_length_i   = '0;
    ack_number_i       = '0;
    out_ready_i        = 1'b0;
    mismatch_count     = 0;
    sender_gap_pct     = 16;
    receiver_stall_pct = 50;
    win_reg            = WIN_RESET;
    tmo_reg            = TMO_RESET;
    win_base           = '0;
    next_seq           = '0;
    tick_count         = '0;
    timer_on           = 1'b0;
    end_seen           = 1'b0;
    eot_sent           = 1'b0;
    foreach (seg_len[i]) seg_len[i] = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_register_extremes();
    test_random_traffic(105, 16, 50, 16'hFFF4, 16'd2);
    test_random_traffic(105, 50, 16, CFG_DATA_W'($urandom_range(5, WINDOW_MAX)), 16'd3);
    test_random_traffic(105, 0, 0, 16'd15, CFG_DATA_W'($urandom_range(1, 4)));
    test_end_of_data();

    settle();
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
rtl/core/gbn_pkg.sv
rtl/core/gbn_front.sv
rtl/core/gbn_cmd_fifo.sv
rtl/core/gbn_back.sv
rtl/core/go_back_n_sender_window_unit.sv
rtl/core/gbn_checker.sv
tb/tb_top.sv
